// ----- rtl/ipm_pkg.sv -----
`default_nettype none
package ipm_pkg;

  localparam int unsigned CoefW   = 32;
  localparam int unsigned FillW   = 8;
  localparam int unsigned NumCoef = 9;
  localparam int unsigned PAddrW  = 6;
  localparam int unsigned PDataW  = 64;
  localparam int unsigned RegIdxW = 3;

  // register map, index = paddr[5:3]
  typedef enum logic [RegIdxW-1:0] {
    RegPairA = 3'd0,
    RegPairB = 3'd1,
    RegPairC = 3'd2,
    RegPairD = 3'd3,
    RegLast  = 3'd4,
    RegLeft  = 3'd5,
    RegRight = 3'd6,
    RegWhite = 3'd7
  } reg_idx_e;

  typedef logic signed [CoefW-1:0] coef_t;

  // h[3*r+c] holds homography entry rc
  typedef struct packed {
    coef_t [NumCoef-1:0]  h;
    logic  [FillW-1:0]    left_fill;
    logic  [FillW-1:0]    right_fill;
    logic  [FillW-1:0]    white_fill;
  } cfg_t;

  // travels beside the data through every stage
  typedef struct packed {
    logic             valid;
    logic [FillW-1:0] fill;
  } side_t;

  typedef struct packed {
    logic dzero;
    logic negx;
    logic negy;
    logic bigx;
    logic bigy;
  } dflag_t;

endpackage
`default_nettype wire

// ----- rtl/ipm_pix_if.sv -----
`default_nettype none
interface ipm_pix_if #(
  parameter int unsigned ColW = 7,
  parameter int unsigned RowW = 7
);
  logic            valid;
  logic            ready;
  logic [ColW-1:0] out_col;
  logic [RowW-1:0] out_row;

  modport source (output valid, output out_col, output out_row, input ready);
  modport sink   (input valid, input out_col, input out_row, output ready);
endinterface
`default_nettype wire

// ----- rtl/ipm_src_if.sv -----
`default_nettype none
interface ipm_src_if #(
  parameter int unsigned ColW = 8,
  parameter int unsigned RowW = 7
);
  logic            valid;
  logic            ready;
  logic [ColW-1:0] src_col;
  logic [RowW-1:0] src_row;
  logic            inside_res;
  logic [7:0]      fill_value;

  modport source (output valid, output src_col, output src_row, output inside_res,
                  output fill_value, input ready);
  modport sink   (input valid, input src_col, input src_row, input inside_res,
                  input fill_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/ipm_regs.sv -----
`default_nettype none
module ipm_regs (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [ipm_pkg::PAddrW-1:0] paddr,
  input  wire logic [ipm_pkg::PDataW-1:0] pwdata,
  output logic      [ipm_pkg::PDataW-1:0] prdata,
  output logic                        pready,
  output ipm_pkg::cfg_t               cfg_o
);
  import ipm_pkg::*;

  logic [63:0]      pair_a_q, pair_b_q, pair_c_q, pair_d_q;
  logic [CoefW-1:0] last_q;
  logic [FillW-1:0] left_q, right_q, white_q;
  logic             wr_en;
  reg_idx_e         idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[PAddrW-1:PAddrW-RegIdxW]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_a_q <= '0;
      pair_b_q <= '0;
      pair_c_q <= '0;
      pair_d_q <= '0;
      last_q   <= '0;
      left_q   <= '0;
      right_q  <= '0;
      white_q  <= '1;
    end else if (wr_en) begin
      unique case (idx)
        RegPairA: pair_a_q <= pwdata;
        RegPairB: pair_b_q <= pwdata;
        RegPairC: pair_c_q <= pwdata;
        RegPairD: pair_d_q <= pwdata;
        RegLast:  last_q   <= pwdata[CoefW-1:0];
        RegLeft:  left_q   <= pwdata[FillW-1:0];
        RegRight: right_q  <= pwdata[FillW-1:0];
        RegWhite: white_q  <= pwdata[FillW-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegPairA: prdata = pair_a_q;
      RegPairB: prdata = pair_b_q;
      RegPairC: prdata = pair_c_q;
      RegPairD: prdata = pair_d_q;
      RegLast:  prdata = PDataW'(last_q);
      RegLeft:  prdata = PDataW'(left_q);
      RegRight: prdata = PDataW'(right_q);
      RegWhite: prdata = PDataW'(white_q);
      default:  prdata = '0;
    endcase
  end

  always_comb begin
    cfg_o.h[0]       = pair_a_q[31:0];
    cfg_o.h[1]       = pair_a_q[63:32];
    cfg_o.h[2]       = pair_b_q[31:0];
    cfg_o.h[3]       = pair_b_q[63:32];
    cfg_o.h[4]       = pair_c_q[31:0];
    cfg_o.h[5]       = pair_c_q[63:32];
    cfg_o.h[6]       = pair_d_q[31:0];
    cfg_o.h[7]       = pair_d_q[63:32];
    cfg_o.h[8]       = last_q;
    cfg_o.left_fill  = left_q;
    cfg_o.right_fill = right_q;
    cfg_o.white_fill = white_q;
  end

endmodule
`default_nettype wire

// ----- rtl/ipm_mac.sv -----
`default_nettype none
module ipm_mac #(
  parameter int unsigned ColW     = 7,
  parameter int unsigned RowW     = 7,
  parameter int unsigned SplitCol = 57,
  parameter int unsigned SplitRow = 84,
  parameter int unsigned NumW     = 42
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   valid_i,
  input  wire logic [ColW-1:0]        col_i,
  input  wire logic [RowW-1:0]        row_i,
  input  wire ipm_pkg::cfg_t          cfg_i,
  output ipm_pkg::side_t              side_o,
  output logic signed [NumW-1:0]      nx_o,
  output logic signed [NumW-1:0]      ny_o,
  output logic signed [NumW-1:0]      den_o
);
  import ipm_pkg::*;

  localparam int unsigned PW   = NumW - 2;
  localparam int unsigned CmpW = 12;

  logic signed [ColW:0]   col_s;
  logic signed [RowW:0]   row_s;
  logic signed [PW-1:0]   prod_d [6];
  logic signed [PW-1:0]   prod_q [6];
  side_t                  side1_d, side1_q, side2_q;
  logic signed [NumW-1:0] nx_q, ny_q, den_q;

  assign col_s = $signed({1'b0, col_i});
  assign row_s = $signed({1'b0, row_i});

  // stage 1: six products
  always_comb begin
    prod_d[0] = $signed(cfg_i.h[0]) * col_s;
    prod_d[1] = $signed(cfg_i.h[1]) * row_s;
    prod_d[2] = $signed(cfg_i.h[3]) * col_s;
    prod_d[3] = $signed(cfg_i.h[4]) * row_s;
    prod_d[4] = $signed(cfg_i.h[6]) * col_s;
    prod_d[5] = $signed(cfg_i.h[7]) * row_s;
    side1_d.valid = valid_i;
    if (CmpW'(row_i) > CmpW'(SplitRow)) begin
      side1_d.fill = (CmpW'(col_i) < CmpW'(SplitCol)) ? cfg_i.left_fill : cfg_i.right_fill;
    end else begin
      side1_d.fill = cfg_i.white_fill;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side1_q <= '0;
      side2_q <= '0;
    end else if (en_i) begin
      side1_q <= side1_d;
      side2_q <= side1_q;
    end
  end

  // stage 2: three-term sums
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      nx_q  <= NumW'(prod_q[0]) + NumW'(prod_q[1]) + NumW'($signed(cfg_i.h[2]));
      ny_q  <= NumW'(prod_q[2]) + NumW'(prod_q[3]) + NumW'($signed(cfg_i.h[5]));
      den_q <= NumW'(prod_q[4]) + NumW'(prod_q[5]) + NumW'($signed(cfg_i.h[8]));
    end
  end

  assign side_o = side2_q;
  assign nx_o   = nx_q;
  assign ny_o   = ny_q;
  assign den_o  = den_q;

endmodule
`default_nettype wire

// ----- rtl/ipm_div.sv -----
`default_nettype none
module ipm_div #(
  parameter int unsigned NumW = 42,
  parameter int unsigned QB   = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire ipm_pkg::side_t         side_i,
  input  wire logic signed [NumW-1:0] nx_i,
  input  wire logic signed [NumW-1:0] ny_i,
  input  wire logic signed [NumW-1:0] den_i,
  output ipm_pkg::side_t              side_o,
  output ipm_pkg::dflag_t             flag_o,
  output logic [QB-1:0]               qx_o,
  output logic [QB-1:0]               qy_o
);
  import ipm_pkg::*;

  localparam int unsigned RW = NumW + QB;

  // magnitude stage
  logic [NumW-1:0] ax_q, ay_q, ad_q;
  side_t           sa_q;
  dflag_t          fa_q;

  // range check and restoring steps: index 0 after the range check
  logic [RW-1:0]   rx_q [QB+1];
  logic [RW-1:0]   ry_q [QB+1];
  logic [NumW-1:0] d_q  [QB+1];
  logic [QB-1:0]   qx_q [QB+1];
  logic [QB-1:0]   qy_q [QB+1];
  side_t           s_q  [QB+1];
  dflag_t          f_q  [QB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_q <= '0;
    end else if (en_i) begin
      sa_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q       <= nx_i[NumW-1] ? NumW'(-nx_i) : NumW'(nx_i);
      ay_q       <= ny_i[NumW-1] ? NumW'(-ny_i) : NumW'(ny_i);
      ad_q       <= den_i[NumW-1] ? NumW'(-den_i) : NumW'(den_i);
      fa_q.dzero <= (den_i == '0);
      fa_q.negx  <= nx_i[NumW-1] ^ den_i[NumW-1];
      fa_q.negy  <= ny_i[NumW-1] ^ den_i[NumW-1];
      fa_q.bigx  <= 1'b0;
      fa_q.bigy  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q[0] <= '0;
    end else if (en_i) begin
      s_q[0] <= sa_q;
    end
  end

  // quotient at least 2**QB lies outside any frame
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q[0]      <= RW'(ax_q);
      ry_q[0]      <= RW'(ay_q);
      d_q[0]       <= ad_q;
      qx_q[0]      <= '0;
      qy_q[0]      <= '0;
      f_q[0].dzero <= fa_q.dzero;
      f_q[0].negx  <= fa_q.negx;
      f_q[0].negy  <= fa_q.negy;
      f_q[0].bigx  <= RW'(ax_q) >= (RW'(ad_q) << QB);
      f_q[0].bigy  <= RW'(ay_q) >= (RW'(ad_q) << QB);
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam int unsigned K = QB - 1 - j;
    logic [RW-1:0] dsh;
    logic          gex, gey;

    assign dsh = RW'(d_q[j]) << K;
    assign gex = rx_q[j] >= dsh;
    assign gey = ry_q[j] >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s_q[j+1] <= '0;
      end else if (en_i) begin
        s_q[j+1] <= s_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[j+1]    <= gex ? rx_q[j] - dsh : rx_q[j];
        ry_q[j+1]    <= gey ? ry_q[j] - dsh : ry_q[j];
        qx_q[j+1]    <= qx_q[j] | (QB'(gex) << K);
        qy_q[j+1]    <= qy_q[j] | (QB'(gey) << K);
        d_q[j+1]     <= d_q[j];
        f_q[j+1]     <= f_q[j];
      end
    end
  end

  assign side_o = s_q[QB];
  assign flag_o = f_q[QB];
  assign qx_o   = qx_q[QB];
  assign qy_o   = qy_q[QB];

endmodule
`default_nettype wire

// ----- rtl/inverse_perspective_pixel_map.sv -----
// Pipeline: QB + 5 register stages, QB = clog2(max(SRC_COLS, SRC_ROWS)); a pixel
//   transferred in passes through every stage before it can transfer out.
// Throughput: one pixel per cycle; the whole pipeline advances together and
//   holds while a finished result waits, so nothing is dropped or repeated.
// Reset: rst_ni async low; clears all valid bits, coefficients to zero,
//   left/right fill to 0 and white fill to 255.
`default_nettype none
module inverse_perspective_pixel_map #(
  parameter int unsigned OUT_COLS  = 114,
  parameter int unsigned OUT_ROWS  = 100,
  parameter int unsigned SRC_ROWS  = 120,
  parameter int unsigned SRC_COLS  = 188,
  parameter int unsigned SPLIT_COL = 57,
  parameter int unsigned SPLIT_ROW = 84
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  ipm_pix_if.sink                         pix_i,
  ipm_src_if.source                       src_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ipm_pkg::PAddrW-1:0] paddr,
  input  wire logic [ipm_pkg::PDataW-1:0] pwdata,
  output logic      [ipm_pkg::PDataW-1:0] prdata,
  output logic                            pready
);
  import ipm_pkg::*;

  localparam int unsigned ColW  = $clog2(OUT_COLS);
  localparam int unsigned RowW  = $clog2(OUT_ROWS);
  localparam int unsigned SColW = $clog2(SRC_COLS);
  localparam int unsigned SRowW = $clog2(SRC_ROWS);
  localparam int unsigned QB    = (SColW > SRowW) ? SColW : SRowW;
  localparam int unsigned MaxW  = (ColW > RowW) ? ColW : RowW;
  // Q8.24 coefficient times unsigned pixel index, plus two bits of sum growth
  localparam int unsigned NumW  = CoefW + 1 + MaxW + 2;

  cfg_t                   cfg;
  logic                   en;
  side_t                  mac_side, div_side;
  dflag_t                 flag;
  logic signed [NumW-1:0] nx, ny, den;
  logic [QB-1:0]          qx, qy;
  logic                   okx, oky, in_frame;

  logic                   out_valid_q;
  logic [SColW-1:0]       src_col_q;
  logic [SRowW-1:0]       src_row_q;
  logic                   inside_q;
  logic [FillW-1:0]       fill_q;

  // Single stall signal for the whole pipe: it moves whenever the output
  // register is empty or being drained in this cycle.
  assign en          = !out_valid_q || src_o.ready;
  assign pix_i.ready = en;

  ipm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // two stages: products, then numerator/denominator sums
  ipm_mac #(
    .ColW     (ColW),
    .RowW     (RowW),
    .SplitCol (SPLIT_COL),
    .SplitRow (SPLIT_ROW),
    .NumW     (NumW)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pix_i.valid),
    .col_i   (pix_i.out_col),
    .row_i   (pix_i.out_row),
    .cfg_i   (cfg),
    .side_o  (mac_side),
    .nx_o    (nx),
    .ny_o    (ny),
    .den_o   (den)
  );

  // magnitudes, range check, then one restoring quotient bit per stage
  ipm_div #(
    .NumW (NumW),
    .QB   (QB)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .side_i (mac_side),
    .nx_i   (nx),
    .ny_i   (ny),
    .den_i  (den),
    .side_o (div_side),
    .flag_o (flag),
    .qx_o   (qx),
    .qy_o   (qy)
  );

  // Truncation toward zero: a negative quotient with zero magnitude
  // (a small negative value) still maps to coordinate 0 and counts as inside.
  assign okx      = !flag.bigx && (!flag.negx || qx == '0) &&
                    ((QB+1)'(qx) < (QB+1)'(SRC_COLS));
  assign oky      = !flag.bigy && (!flag.negy || qy == '0) &&
                    ((QB+1)'(qy) < (QB+1)'(SRC_ROWS));
  assign in_frame = !flag.dzero && okx && oky;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div_side.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      inside_q  <= in_frame;
      src_col_q <= in_frame ? qx[SColW-1:0] : '0;
      src_row_q <= in_frame ? qy[SRowW-1:0] : '0;
      fill_q    <= in_frame ? '0 : div_side.fill;
    end
  end

  assign src_o.valid      = out_valid_q;
  assign src_o.src_col    = src_col_q;
  assign src_o.src_row    = src_row_q;
  assign src_o.inside_res = inside_q;
  assign src_o.fill_value = fill_q;

  // an inside pixel never carries a fill, an outside one never a coordinate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && inside_q |-> fill_q == '0)
    else $error("fill set on inside pixel");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !inside_q |-> src_col_q == '0 && src_row_q == '0)
    else $error("coordinate set on outside pixel");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && inside_q |->
      (QB+1)'(src_col_q) < (QB+1)'(SRC_COLS) && (QB+1)'(src_row_q) < (QB+1)'(SRC_ROWS))
    else $error("inside coordinate beyond frame");

  // a transfer in must appear as valid at the first pipeline stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.valid && en |=> u_mac.side1_q.valid)
    else $error("accepted pixel lost in first stage");

endmodule
`default_nettype wire

// ----- sim/inverse_perspective_pixel_map_test.sv -----
module inverse_perspective_pixel_map_test;
  import ipm_pkg::*;

  localparam int SrcCols  = 188;
  localparam int SrcRows  = 120;
  localparam int SplitCol = 57;
  localparam int SplitRow = 84;
  localparam int Latency  = 13;
  localparam int StallLimit = 2000;  // idle cycles with no transfer before giving up

  // pixel request and mapping result as the testbench sees them
  typedef struct packed {
    logic [6:0] col;
    logic [6:0] row;
  } pix_t;

  typedef struct packed {
    logic [7:0] scol;
    logic [6:0] srow;
    logic       hit;
    logic [7:0] fill;
  } map_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PAddrW-1:0] paddr = '0;
  logic [PDataW-1:0] pwdata = '0;
  logic [PDataW-1:0] prdata;
  logic              pready;

  ipm_pix_if pix ();
  ipm_src_if src ();

  inverse_perspective_pixel_map u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix.sink),
    .src_o   (src.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // shadow copy of the register file used by the mapping predictor
  logic signed [31:0] hm [9];
  logic [7:0] fill_left, fill_right, fill_white;

  pix_t pending_pix[$];
  map_t expected_map[$];
  int   mismatches = 0;
  int   results_seen = 0;
  int   inside_seen = 0;
  int   zero_den_seen = 0;
  int   idle_cycles = 0;
  bit   driving_done = 1'b0;

  // transfers seen at the last rising edge, used by the falling-edge drivers
  bit   pix_fired = 1'b0;
  bit   src_fired = 1'b0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH result %0d: %s got %0h want %0h", results_seen, what, got, want);
    mismatches++;
  endtask

  // homography predictor: exact integer division truncating toward zero
  function automatic map_t predict_map(input pix_t p);
    map_t m;
    longint c, r, nx, ny, dn, qx, qy;
    bit in_frame;
    c  = longint'(p.col);
    r  = longint'(p.row);
    nx = longint'(hm[0]) * c + longint'(hm[1]) * r + longint'(hm[2]);
    ny = longint'(hm[3]) * c + longint'(hm[4]) * r + longint'(hm[5]);
    dn = longint'(hm[6]) * c + longint'(hm[7]) * r + longint'(hm[8]);
    in_frame = 1'b0;
    if (dn != 0) begin
      qx = nx / dn;
      qy = ny / dn;
      in_frame = qx >= 0 && qy >= 0 && qx < SrcCols && qy < SrcRows;
    end
    m = '0;
    if (in_frame) begin
      m.scol = qx[7:0];
      m.srow = qy[6:0];
      m.hit  = 1'b1;
    end else if (r > SplitRow) begin
      m.fill = (c < SplitCol) ? fill_left : fill_right;
    end else begin
      m.fill = fill_white;
    end
    return m;
  endfunction

  // APB write: setup cycle then access cycle, changes at falling edge
  task automatic reg_write(input reg_idx_e idx, input logic [63:0] val);
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = PAddrW'({idx, 3'b000}); pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      RegPairA: begin hm[0] = val[31:0]; hm[1] = val[63:32]; end
      RegPairB: begin hm[2] = val[31:0]; hm[3] = val[63:32]; end
      RegPairC: begin hm[4] = val[31:0]; hm[5] = val[63:32]; end
      RegPairD: begin hm[6] = val[31:0]; hm[7] = val[63:32]; end
      RegLast:  hm[8] = val[31:0];
      RegLeft:  fill_left = val[7:0];
      RegRight: fill_right = val[7:0];
      RegWhite: fill_white = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_matrix(input logic [31:0] h [9]);
    reg_write(RegPairA, {h[1], h[0]});
    reg_write(RegPairB, {h[3], h[2]});
    reg_write(RegPairC, {h[5], h[4]});
    reg_write(RegPairD, {h[7], h[6]});
    reg_write(RegLast, {32'h0, h[8]});
  endtask

  // wait for every expected transfer, then let the pipe drain
  task automatic wait_idle();
    while (pending_pix.size() != 0 || expected_map.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] q24(input real v);
    return 32'($rtoi(v * 16777216.0));
  endfunction

  function automatic logic [31:0] rand_coef(input int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8191)) - 4096) << $urandom_range(0, 22);
      default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
    endcase
  endfunction

  always @(posedge clk_i) begin
    pix_fired <= pix.valid && pix.ready;
    src_fired <= src.valid && src.ready;
  end

  // driver: offers the oldest pending pixel, random gap after each one
  int pix_gap = 0;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix.valid   <= 1'b0;
      pix.out_col <= '0;
      pix.out_row <= '0;
      pix_gap     <= 0;
    end else if (pix.valid && !pix_fired) begin
      // hold the offer until it is taken
    end else if (pix_gap > 0) begin
      pix.valid <= 1'b0;
      pix_gap   <= pix_gap - 1;
    end else if (pending_pix.size() != 0) begin
      pix.valid   <= 1'b1;
      pix.out_col <= pending_pix[0].col;
      pix.out_row <= pending_pix[0].row;
      pix_gap     <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12) * $urandom_range(0, 1);
    end else begin
      pix.valid <= 1'b0;
    end
  end

  // sink-side stall, redrawn per result
  int src_stall = 0;
  always @(negedge clk_i or negedge rst_ni) begin
    int wait_n;
    if (!rst_ni) begin
      src.ready <= 1'b0;
      src_stall <= 0;
    end else if (src_fired) begin
      wait_n = $urandom_range(0, 12) * $urandom_range(0, 1);
      src_stall <= wait_n;
      src.ready <= (wait_n == 0);
    end else if (src_stall > 0) begin
      src.ready <= (src_stall == 1);
      src_stall <= src_stall - 1;
    end else begin
      src.ready <= 1'b1;
    end
  end

  // monitor: input transfers make predictions, output transfers are checked
  always @(posedge clk_i) begin
    map_t want;
    if (rst_ni) begin
      if (pix.valid && pix.ready) begin
        expected_map.push_back(predict_map(pending_pix.pop_front()));
        idle_cycles = 0;
      end
      if (src.valid && src.ready) begin
        idle_cycles = 0;
        if (expected_map.size() == 0) begin
          report("unexpected transfer", 0, 0);
        end else begin
          want = expected_map.pop_front();
          if (src.src_col !== want.scol) report("src_col", src.src_col, want.scol);
          if (src.src_row !== want.srow) report("src_row", src.src_row, want.srow);
          if (src.inside_res !== want.hit) report("inside_res", src.inside_res, want.hit);
          if (src.fill_value !== want.fill) report("fill_value", src.fill_value, want.fill);
          if (want.hit) inside_seen++;
        end
        results_seen++;
      end
      if (!(pix.valid && pix.ready) && !(src.valid && src.ready)) idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("watchdog: no transfer for %0d cycles", StallLimit);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // push one pixel and note zero denominators for the summary
  task automatic add_pix(input int c, input int r);
    pix_t p;
    p.col = c[6:0];
    p.row = r[6:0];
    if (longint'(hm[6]) * c + longint'(hm[7]) * r + longint'(hm[8]) == 0) zero_den_seen++;
    pending_pix.push_back(p);
  endtask

  initial begin
    logic [31:0] h [9];
    int mode;
    for (int i = 0; i < 9; i++) hm[i] = '0;
    fill_left = 8'd0; fill_right = 8'd0; fill_white = 8'd255;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset values: zero denominator everywhere, all pixels get fills
    add_pix(0, 0); add_pix(127, 127); add_pix(56, 85); add_pix(57, 85); add_pix(10, 84);
    wait_idle();

    // camera-style matrix with distinct fills
    h = '{q24(0.209024), q24(-0.166388), q24(10.855739),
          q24(-0.003405), q24(0.013697), q24(4.739457),
          q24(0.000026), q24(-0.001729), q24(0.237276)};
    load_matrix(h);
    reg_write(RegLeft, 64'h11);
    reg_write(RegRight, 64'hee);
    reg_write(RegWhite, 64'h80);
    add_pix(0, 0); add_pix(113, 99); add_pix(56, 84); add_pix(57, 85); add_pix(56, 85);
    add_pix(127, 0); add_pix(0, 127); add_pix(127, 127); add_pix(57, 50);
    wait_idle();

    // identity-ish scale: small negative quotients truncate to zero and stay inside,
    // denominator zero on one row via h21 cancelling h22
    h = '{32'sd1, 32'sd0, -32'sd1, 32'sd0, 32'sd1, -32'sd2,
          32'sd0, -32'sd1, 32'sd3};
    load_matrix(h);
    reg_write(RegLeft, 64'hff);
    reg_write(RegRight, 64'h00);
    reg_write(RegWhite, 64'h00);
    add_pix(0, 0); add_pix(1, 1); add_pix(0, 3); add_pix(100, 3); add_pix(90, 100);
    add_pix(10, 120);
    wait_idle();

    // random phases: coefficient sets, fills and pixels
    for (int ph = 0; ph < 22; ph++) begin
      mode = ph % 3;
      for (int i = 0; i < 9; i++) h[i] = rand_coef(mode);
      if (ph % 4 == 1) begin
        // mostly-inside maps: scale and offset chosen to land in the frame
        h = '{32'($urandom_range(1, 3)), 32'sd0, 32'($urandom_range(0, 20)),
              32'sd0, 32'($urandom_range(1, 2)), -32'($urandom_range(0, 20)),
              32'sd0, 32'sd0, 32'($urandom_range(1, 2))};
      end
      if (ph % 7 == 3) begin
        h[6] = 32'sd0; h[7] = 32'sd0; h[8] = 32'sd0;
      end
      load_matrix(h);
      reg_write(RegLeft, {$urandom(), $urandom()});
      reg_write(RegRight, {$urandom(), $urandom()});
      reg_write(RegWhite, {$urandom(), $urandom()});
      for (int k = 0; k < 50; k++) begin
        if ($urandom_range(0, 9) == 0) add_pix($urandom_range(0, 127), $urandom_range(0, 127));
        else add_pix($urandom_range(0, 113), $urandom_range(0, 99));
      end
      wait_idle();
    end

    $display("covered %0d mappings, %0d inside the frame, %0d with zero denominator",
             results_seen, inside_seen, zero_den_seen);
    $display("register sets: reset, camera matrix, hand-built cases and 22 random phases");
    if (mismatches == 0 && expected_map.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
